@@ rtl/core/rpn_pkg.sv @@
// Shared constants, token and status codes, and the controller-to-datapath
// command and status bundles of the RPN stack evaluator. No dependencies.
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;

  // token operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_END  = 3'd5;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_FEW   = 3'd1;
  localparam logic [ST_W-1:0] ST_DIV0  = 3'd2;
  localparam logic [ST_W-1:0] ST_OVF   = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;
  localparam logic [ST_W-1:0] ST_EXTRA = 3'd5;

  typedef struct packed {
    logic            rd_en;       // stack read, data registered
    logic            wr_en;       // stack write
    logic            wr_push;     // write data: 1 = input number, 0 = result
    logic            a_load;      // capture top operand from read data
    logic            b_load;      // capture second operand from read data
    logic            prod_load;   // capture magnitude product
    logic            div_start;   // start iterative divide
    logic            res_load;    // capture rounded, saturated result
    logic            out_load;    // load output register
    logic            out_sel_rd;  // output value: 1 = read data, 0 = zero
    logic [OP_W-1:0] alu_op;
    logic [ST_W-1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic a_zero;
    logic div_done;
  } sts_t;

endpackage

@@ rtl/core/rpn_div.sv @@
// Restoring divider for the RPN evaluator, one quotient bit per cycle.
// Depends on rpn_pkg for the data width.
module rpn_div #(
  parameter int NUM_W = rpn_pkg::DATA_W + rpn_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NUM_W-1:0]          dividend,
  input  logic [rpn_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [NUM_W-1:0]          quo,
  output logic [rpn_pkg::DATA_W-1:0] rem
);

  localparam int DW    = rpn_pkg::DATA_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] step_r;
  logic [NUM_W-1:0] quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    dvs_r;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - CNT_W'(1);
        if (step_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so DW bits hold it
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/rpn_dp.sv @@
// Datapath of the RPN evaluator: operand stack memory, operand registers,
// add/sub/mul/div with rounding and saturation, output register.
// Depends on rpn_pkg and rpn_div.
module rpn_dp #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF,
  localparam int IDX_W      = $clog2(STACK_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rpn_pkg::cmd_t                cmd,
  input  logic [IDX_W-1:0]             rd_addr,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic [rpn_pkg::DATA_W-1:0]   in_number,
  output rpn_pkg::sts_t                sts,
  output logic [rpn_pkg::DATA_W-1:0]   out_value,
  output logic [rpn_pkg::ST_W-1:0]     out_status
);

  localparam int DW    = rpn_pkg::DATA_W;
  localparam int NUM_W = DW + FRAC_BITS;
  localparam logic [2*DW-1:0] HALF = (64'd1 << FRAC_BITS) >> 1;

  function automatic logic [DW-1:0] mag32(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + DW'(1)) : x;
  endfunction

  function automatic logic [DW-1:0] sat_sum(input logic [DW:0] v);
    if (v[DW] != v[DW-1]) begin
      return v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return v[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] sat_mag(input logic neg, input logic [2*DW-1:0] m);
    if (neg) begin
      if (m >= (64'd1 << (DW - 1))) begin
        return {1'b1, {(DW-1){1'b0}}};
      end
      return ~m[DW-1:0] + DW'(1);
    end
    if (m > {{(DW+1){1'b0}}, {(DW-1){1'b1}}}) begin
      return {1'b0, {(DW-1){1'b1}}};
    end
    return m[DW-1:0];
  endfunction

  logic [DW-1:0]   mem [STACK_DEPTH];
  logic [DW-1:0]   rd_q_r;
  logic [DW-1:0]   a_r, b_r, ma_r, mb_r;
  logic [2*DW-1:0] prod_r;
  logic [DW-1:0]   res_r, res_nxt;
  logic [DW-1:0]   out_value_r;
  logic [rpn_pkg::ST_W-1:0] out_status_r;

  logic             neg;
  logic             div_done;
  logic [NUM_W-1:0] quo;
  logic [DW-1:0]    rem;
  logic             round_up;
  logic [DW:0]      sum_c, dif_c;
  logic [2*DW-1:0]  prod_c, mul_m, div_m;

  rpn_div #(.NUM_W(NUM_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (NUM_W'(mb_r) << FRAC_BITS),
    .divisor  (ma_r),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_push ? in_number : res_r;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign neg      = a_r[DW-1] ^ b_r[DW-1];
  assign sum_c    = {b_r[DW-1], b_r} + {a_r[DW-1], a_r};
  assign dif_c    = {b_r[DW-1], b_r} - {a_r[DW-1], a_r};
  assign prod_c   = ma_r * mb_r;
  assign mul_m    = (prod_r + HALF) >> FRAC_BITS;
  // round to nearest, ties away from zero: 2r >= divisor
  assign round_up = ({rem, 1'b0} >= {1'b0, ma_r});
  assign div_m    = (2*DW)'(quo) + (2*DW)'(round_up);

  always_comb begin
    case (cmd.alu_op)
      rpn_pkg::OP_ADD: res_nxt = sat_sum(sum_c);
      rpn_pkg::OP_SUB: res_nxt = sat_sum(dif_c);
      rpn_pkg::OP_MUL: res_nxt = sat_mag(neg, mul_m);
      rpn_pkg::OP_DIV: res_nxt = sat_mag(neg, div_m);
      default:         res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.a_load) begin
      a_r  <= rd_q_r;
      ma_r <= mag32(rd_q_r);
    end
    if (cmd.b_load) begin
      b_r  <= rd_q_r;
      mb_r <= mag32(rd_q_r);
    end
    if (cmd.prod_load) begin
      prod_r <= prod_c;
    end
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
    if (cmd.out_load) begin
      out_value_r  <= cmd.out_sel_rd ? rd_q_r : '0;
      out_status_r <= cmd.out_status;
    end
  end

  assign sts.a_zero   = (ma_r == '0);
  assign sts.div_done = div_done;
  assign out_value    = out_value_r;
  assign out_status   = out_status_r;

endmodule

@@ rtl/core/rpn_ctrl.sv @@
// Controller of the RPN evaluator: token decode, stack count, error latch,
// operation sequencing and output valid. Depends on rpn_pkg.
module rpn_ctrl #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  localparam int IDX_W      = $clog2(STACK_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [rpn_pkg::OP_W-1:0]   in_op,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output rpn_pkg::cmd_t              cmd,
  output logic [IDX_W-1:0]           rd_addr,
  output logic [IDX_W-1:0]           wr_addr,
  input  rpn_pkg::sts_t              sts
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_A = 3'd1;
  localparam logic [2:0] S_RD_B = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     err_r, err_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [rpn_pkg::OP_W-1:0] op_r, op_nxt;
  logic [rpn_pkg::ST_W-1:0] st_r, st_nxt;
  logic                     sel_r, sel_nxt;

  logic             in_accept;
  logic [CNT_W-1:0] cnt_m1, cnt_m2;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid & in_tready;
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign cnt_m2    = cnt_r - CNT_W'(2);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    op_nxt         = op_r;
    st_nxt         = st_r;
    sel_nxt        = sel_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    cmd            = '0;
    cmd.alu_op     = op_r;
    cmd.out_status = st_r;
    cmd.out_sel_rd = sel_r;
    rd_addr        = '0;
    wr_addr        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_op)
            rpn_pkg::OP_END: begin
              cnt_nxt = '0;
              if (err_r) begin
                err_nxt = 1'b0;
              end else if (cnt_r == '0) begin
                st_nxt    = rpn_pkg::ST_EMPTY;
                sel_nxt   = 1'b0;
                state_nxt = S_EMIT;
              end else if (cnt_r == CNT_W'(1)) begin
                cmd.rd_en = 1'b1;
                st_nxt    = rpn_pkg::ST_OK;
                sel_nxt   = 1'b1;
                state_nxt = S_EMIT;
              end else begin
                st_nxt    = rpn_pkg::ST_EXTRA;
                sel_nxt   = 1'b0;
                state_nxt = S_EMIT;
              end
            end
            rpn_pkg::OP_PUSH: begin
              if (!err_r) begin
                if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                  cnt_nxt   = '0;
                  err_nxt   = 1'b1;
                  st_nxt    = rpn_pkg::ST_OVF;
                  sel_nxt   = 1'b0;
                  state_nxt = S_EMIT;
                end else begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_push = 1'b1;
                  wr_addr     = cnt_r[IDX_W-1:0];
                  cnt_nxt     = cnt_r + CNT_W'(1);
                end
              end
            end
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
              if (!err_r) begin
                if (cnt_r < CNT_W'(2)) begin
                  cnt_nxt   = '0;
                  err_nxt   = 1'b1;
                  st_nxt    = rpn_pkg::ST_FEW;
                  sel_nxt   = 1'b0;
                  state_nxt = S_EMIT;
                end else begin
                  cmd.rd_en = 1'b1;
                  rd_addr   = cnt_m1[IDX_W-1:0];
                  op_nxt    = in_op;
                  state_nxt = S_RD_A;
                end
              end
            end
            default: ;  // unused codes are dropped
          endcase
        end
      end
      S_RD_A: begin
        cmd.a_load = 1'b1;
        cmd.rd_en  = 1'b1;
        rd_addr    = cnt_m2[IDX_W-1:0];
        state_nxt  = S_RD_B;
      end
      S_RD_B: begin
        cmd.b_load = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        case (op_r)
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
            cmd.res_load = 1'b1;
            state_nxt    = S_WB;
          end
          rpn_pkg::OP_MUL: begin
            cmd.prod_load = 1'b1;
            state_nxt     = S_MUL2;
          end
          rpn_pkg::OP_DIV: begin
            if (sts.a_zero) begin
              cnt_nxt   = '0;
              err_nxt   = 1'b1;
              st_nxt    = rpn_pkg::ST_DIV0;
              sel_nxt   = 1'b0;
              state_nxt = S_EMIT;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MUL2: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_WB;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_WB;
        end
      end
      S_WB: begin
        // b's slot takes the result, a's slot is popped
        cmd.wr_en = 1'b1;
        wr_addr   = cnt_m2[IDX_W-1:0];
        cnt_nxt   = cnt_m1;
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    st_r  <= st_nxt;
    sel_r <= sel_nxt;
  end

  assign out_tvalid = out_valid_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register reloaded while a result is pending");

  a_emit_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r == '0))
    else $error("result emitted with operands still on the stack");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.a_zero)
    else $error("divide started with zero divisor");

  a_pop_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (cnt_r >= CNT_W'(2)))
    else $error("write-back with fewer than two operands");

endmodule

@@ rtl/core/rpn_stack_evaluator.sv @@
// RPN stack evaluator top level: stream ports, controller and datapath.
// Depends on rpn_pkg, rpn_ctrl, rpn_dp (and rpn_div below it).
//
// Usage:
//   Input stream: one pre-parsed token per transaction. in_tuser carries the
//   operation (push, add, sub, mul, div, end), in_tdata the Q16.16 number.
//   Output stream: one result per error, or per end token when no error is latched, with the
//   value on out_tdata and the status code on out_tuser.
// Token handling (taken when in_tready is high): a push writes the stack and
//   leaves the block idle; add/sub read both operands, execute and write back;
//   mul adds a product step; div waits on the one-bit-per-cycle restoring
//   divider (Q16.16 by default). An end token, a token that fails at decode, or
//   a divide by zero after the operand reads, sets out_tvalid via the emit state.
// The result sits in an output register, so the next tokens are accepted
// while a result waits; a second result waits in the controller until the
// receiver takes the first one, and in_tready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the stack, clears the error latch
// and drops out_tvalid. After an error the block drops tokens until the next
// end token.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] number
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [2:0]  out_tuser   // [2:0] status
);

  localparam int IDX_W = $clog2(STACK_DEPTH);

  rpn_pkg::cmd_t    cmd;
  rpn_pkg::sts_t    sts;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  rpn_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .sts        (sts)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .in_number  (in_tdata),
    .sts        (sts),
    .out_value  (out_tdata),
    .out_status (out_tuser)
  );

endmodule
